// ===== rtl/fds_pkg.sv =====
// ----------------------------------------------------------------------------
// fds_pkg
// Constants, types and the control store of the frame duplicate suppressor.
// ----------------------------------------------------------------------------
package fds_pkg;

    localparam int CACHE_DEPTH = 32;
    localparam int IDX_W       = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(CACHE_DEPTH + 1);

    localparam int BYTE_W      = 8;
    localparam int HASH_W      = 32;
    localparam int TIME_W      = 32;
    localparam int WIN_W       = 16;
    localparam int PRIME_W     = 25;

    localparam logic [HASH_W-1:0]  HASH_BASIS   = 32'd2166136261;
    localparam logic [PRIME_W-1:0] HASH_PRIME   = 25'd16777619;
    localparam logic [WIN_W-1:0]   WINDOW_RESET = 16'd600;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [HASH_W-1:0] hash_t;
    typedef logic [TIME_W-1:0] stamp_t;
    typedef logic [WIN_W-1:0]  window_t;
    typedef logic [BYTE_W-1:0] octet_t;

    // program steps
    typedef logic [2:0] step_t;
    localparam step_t ST_IDLE  = 3'd0;
    localparam step_t ST_FOLD  = 3'd1;
    localparam step_t ST_SCAN  = 3'd2;
    localparam step_t ST_DRAIN = 3'd3;
    localparam step_t ST_DONE  = 3'd4;

    // branch conditions
    typedef enum logic [2:0] {
        COND_ALWAYS   = 3'd0,
        COND_ACCEPT   = 3'd1,
        COND_LAST     = 3'd2,
        COND_SCAN_END = 3'd3,
        COND_OUT_FREE = 3'd4
    } cond_t;

    typedef struct packed {
        logic  take;     // input ready
        logic  fold;     // multiply the latched xor by the prime
        logic  scan;     // issue a cache read and advance the scan index
        logic  check;    // compare the read data of the previous cycle
        logic  finish;   // deliver result, update ring, restart hash
        cond_t cond;
        step_t target_t; // taken when cond holds
        step_t target_f; // taken otherwise
    } ctrl_t;

    function automatic ctrl_t ucode(input step_t step);
        ctrl_t cw;
        cw = '{take: 1'b0, fold: 1'b0, scan: 1'b0, check: 1'b0, finish: 1'b0,
               cond: COND_ALWAYS, target_t: ST_IDLE, target_f: ST_IDLE};
        case (step)
            ST_IDLE:
            begin
                cw.take     = 1'b1;
                cw.cond     = COND_ACCEPT;
                cw.target_t = ST_FOLD;
                cw.target_f = ST_IDLE;
            end
            ST_FOLD:
            begin
                cw.fold     = 1'b1;
                cw.cond     = COND_LAST;
                cw.target_t = ST_SCAN;
                cw.target_f = ST_IDLE;
            end
            ST_SCAN:
            begin
                cw.scan     = 1'b1;
                cw.check    = 1'b1;
                cw.cond     = COND_SCAN_END;
                cw.target_t = ST_DRAIN;
                cw.target_f = ST_SCAN;
            end
            ST_DRAIN:
            begin
                cw.check    = 1'b1;
                cw.cond     = COND_ALWAYS;
                cw.target_t = ST_DONE;
                cw.target_f = ST_DONE;
            end
            ST_DONE:
            begin
                cw.finish   = 1'b1;
                cw.cond     = COND_OUT_FREE;
                cw.target_t = ST_IDLE;
                cw.target_f = ST_DONE;
            end
            default:
            begin
                cw.cond     = COND_ALWAYS;
                cw.target_t = ST_IDLE;
                cw.target_f = ST_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

// ===== rtl/fds_if.sv =====
// ----------------------------------------------------------------------------
// fds_if
// Handshake channels of the frame duplicate suppressor.
// ----------------------------------------------------------------------------
interface fds_byte_if;
    logic                  valid;
    logic                  ready;
    logic [7:0]            payload_byte;
    logic                  last_byte;
    logic [31:0]           now_seconds;

    modport source (output valid, payload_byte, last_byte, now_seconds, input ready);
    modport sink   (input valid, payload_byte, last_byte, now_seconds, output ready);
endinterface

interface fds_result_if;
    logic                  valid;
    logic                  ready;
    logic                  is_new;
    logic [31:0]           frame_hash;

    modport source (output valid, is_new, frame_hash, input ready);
    modport sink   (input valid, is_new, frame_hash, output ready);
endinterface

interface fds_cfg_if;
    logic                  valid;
    logic                  ready;
    logic [15:0]           window_seconds;

    modport source (output valid, window_seconds, input ready);
    modport sink   (input valid, window_seconds, output ready);
endinterface

// ===== rtl/frame_duplicate_suppressor.sv =====
// ----------------------------------------------------------------------------
// frame_duplicate_suppressor
// FNV-1a 32-bit frame hash with a ring cache of recently seen frames.
// ----------------------------------------------------------------------------
// Payload bytes arrive on rx, one per transfer; a byte that is not last is
// accepted, then folded by one multiply step. On the last byte the hash is
// compared against every filled entry of a 32-entry ring cache, read one entry
// per cycle from a single read port, then DRAIN and DONE run before the next
// byte is taken. One result transfer per frame gives the hash and whether it
// is new; a new frame takes the next free entry, or the oldest once full. The
// output register lets the next frame start while a result waits. The user is
// to write window_seconds (reset 600) on cfg only while idle; not enforced.
module frame_duplicate_suppressor
(
    input  logic clk,
    input  logic rst_n,
    fds_byte_if.sink     rx,
    fds_result_if.source result,
    fds_cfg_if.sink      cfg
);
    import fds_pkg::*;

    ctrl_t   cw;
    step_t   step_reg, step_next;
    logic    cond_ok;

    window_t window_reg;
    hash_t   hash_reg, hash_next;
    hash_t   mix_reg;
    logic    last_reg;
    stamp_t  now_reg;

    cnt_t    fill_reg, fill_next;
    idx_t    wp_reg, wp_next;
    cnt_t    scan_reg, scan_next;
    logic    cmp_vld_reg, cmp_vld_next;
    logic    hit_reg, hit_next;

    logic    out_vld_reg, out_vld_next;
    logic    out_new_reg;
    hash_t   out_hash_reg;

    hash_t   hash_mem [CACHE_DEPTH];
    stamp_t  time_mem [CACHE_DEPTH];
    hash_t   rd_hash_reg;
    stamp_t  rd_time_reg;

    logic    accept;
    logic    out_free;
    logic    finish_go;
    logic    scan_end;
    logic    issue;
    logic    match;
    stamp_t  age;
    logic [HASH_W+PRIME_W-1:0] product;

    assign cw        = ucode(step_reg);
    assign accept    = rx.valid && cw.take;
    assign out_free  = !out_vld_reg || result.ready;
    assign finish_go = cw.finish && out_free;
    assign scan_end  = (scan_reg == fill_reg);
    assign issue     = cw.scan && !scan_end;
    assign product   = mix_reg * HASH_PRIME;

    assign age   = now_reg - rd_time_reg;
    assign match = cmp_vld_reg && (rd_hash_reg == hash_reg)
                   && (age < {{(TIME_W-WIN_W){1'b0}}, window_reg});

    always_comb
    begin
        case (cw.cond)
            COND_ALWAYS:   cond_ok = 1'b1;
            COND_ACCEPT:   cond_ok = accept;
            COND_LAST:     cond_ok = last_reg;
            COND_SCAN_END: cond_ok = scan_end;
            COND_OUT_FREE: cond_ok = out_free;
            default:       cond_ok = 1'b1;
        endcase
        step_next = cond_ok ? cw.target_t : cw.target_f;
    end

    always_comb
    begin
        hash_next    = hash_reg;
        scan_next    = scan_reg;
        cmp_vld_next = cw.scan && issue;
        hit_next     = hit_reg;
        fill_next    = fill_reg;
        wp_next      = wp_reg;
        out_vld_next = out_vld_reg && !result.ready;

        if (cw.fold)
        begin
            hash_next = product[HASH_W-1:0];
            scan_next = '0;
            hit_next  = 1'b0;
        end
        if (issue)
        begin
            scan_next = scan_reg + cnt_t'(1);
        end
        if (cw.check && match)
        begin
            hit_next = 1'b1;
        end
        if (finish_go)
        begin
            hash_next    = HASH_BASIS;
            out_vld_next = 1'b1;
            if (!hit_reg)
            begin
                wp_next = (wp_reg == idx_t'(CACHE_DEPTH - 1)) ? '0 : wp_reg + idx_t'(1);
                if (fill_reg != cnt_t'(CACHE_DEPTH))
                begin
                    fill_next = fill_reg + cnt_t'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= ST_IDLE;
            window_reg  <= WINDOW_RESET;
            hash_reg    <= HASH_BASIS;
            fill_reg    <= '0;
            wp_reg      <= '0;
            scan_reg    <= '0;
            cmp_vld_reg <= 1'b0;
            hit_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            step_reg    <= step_next;
            hash_reg    <= hash_next;
            fill_reg    <= fill_next;
            wp_reg      <= wp_next;
            scan_reg    <= scan_next;
            cmp_vld_reg <= cmp_vld_next;
            hit_reg     <= hit_next;
            out_vld_reg <= out_vld_next;
            if (cfg.valid)
            begin
                window_reg <= cfg.window_seconds;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mix_reg  <= hash_reg ^ {{(HASH_W-BYTE_W){1'b0}}, rx.payload_byte};
            last_reg <= rx.last_byte;
            now_reg  <= rx.now_seconds;
        end
        if (finish_go)
        begin
            out_new_reg  <= !hit_reg;
            out_hash_reg <= hash_reg;
        end
    end

    // ring cache, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (finish_go && !hit_reg)
        begin
            hash_mem[wp_reg] <= hash_reg;
            time_mem[wp_reg] <= now_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_hash_reg <= hash_mem[scan_reg[IDX_W-1:0]];
            rd_time_reg <= time_mem[scan_reg[IDX_W-1:0]];
        end
    end

    assign rx.ready          = cw.take;
    assign cfg.ready         = 1'b1;
    assign result.valid      = out_vld_reg;
    assign result.is_new     = out_new_reg;
    assign result.frame_hash = out_hash_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= cnt_t'(CACHE_DEPTH))
        else $error("fill count beyond cache depth");

    a_hit_keeps_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (finish_go && hit_reg) |=> ($stable(wp_reg) && $stable(fill_reg)))
        else $error("duplicate frame changed the ring");

    a_new_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (finish_go && !hit_reg) |=> (wp_reg != $past(wp_reg) || CACHE_DEPTH == 1))
        else $error("new frame did not advance the write pointer");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> (scan_reg < fill_reg))
        else $error("cache read beyond filled entries");
`endif

endmodule
